FILE: rtl/core/assert_macros.svh
// assertion macros shared by the shuttle sequencer rtl
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/core/lss_pkg.sv
// shared types, codes and reset values for the shuttle sequencer
// no dependencies; used by lss_step and limit_switch_shuttle_sequencer
`default_nettype none

package lss_pkg;

    localparam int TIMER_BITS_DEFAULT = 16;
    localparam int CFG_ADDR_BITS      = 3;
    localparam int CFG_DATA_BITS      = 16;

    // configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] CFG_NORMAL_SPEED   = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_TURBO_SPEED    = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_TURBO_TICKS    = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_READY_RATIO    = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_UPDATE_PERIOD  = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_BRAKE_INTERVAL = 3'd5;

    // configuration reset values
    localparam logic [14:0] RST_NORMAL_SPEED   = 15'd800;
    localparam logic [14:0] RST_TURBO_SPEED    = 15'd1600;
    localparam logic [15:0] RST_TURBO_TICKS    = 16'd475;
    localparam logic [7:0]  RST_READY_RATIO    = 8'd128;
    localparam logic [9:0]  RST_UPDATE_PERIOD  = 10'd50;
    localparam logic [15:0] RST_BRAKE_INTERVAL = 16'd5000;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_HOME   = 2'd1,
        ACT_CHARGE = 2'd2,
        ACT_READY  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        LOC_UNKNOWN = 2'd0,
        LOC_HOME    = 2'd1,
        LOC_READY   = 2'd2,
        LOC_CHARGE  = 2'd3
    } loc_t;

    typedef enum logic [2:0] {
        MOT_IDLE     = 3'd0,
        MOT_HOMING   = 3'd1,
        MOT_CHARGING = 3'd2,
        MOT_READYING = 3'd3,
        MOT_BRAKING  = 3'd4
    } motion_t;

    typedef struct packed {
        logic [14:0] normal_speed;
        logic [14:0] turbo_speed;
        logic [15:0] turbo_ticks;
        logic [7:0]  ready_ratio;
        logic [9:0]  update_period;
        logic [15:0] brake_interval;
    } lss_cfg_t;

    typedef struct packed {
        action_t action;
        logic    turbo_request;
        logic    home_switch;
        logic    charge_switch;
        logic    ready_switch;
    } lss_item_t;

    // sequencer state apart from the timers, whose width is a parameter
    typedef struct packed {
        loc_t        where_now;
        logic        move_lock;
        logic        turbo_blocked;
        logic        turbo_on;
        motion_t     motion;
        logic [9:0]  update_left;
    } lss_state_t;

    typedef struct packed {
        logic signed [15:0] velocity;
        logic               velocity_write;
        logic               brake_pulse;
        loc_t               location;
        logic               busy_res;
        logic               accepted;
        logic               arrived;
    } lss_result_t;

    localparam lss_state_t STATE_RESET = '{
        where_now:     LOC_UNKNOWN,
        move_lock:     1'b0,
        turbo_blocked: 1'b1,
        turbo_on:      1'b0,
        motion:        MOT_IDLE,
        update_left:   10'd0
    };

endpackage

`default_nettype wire

FILE: rtl/core/lss_step.sv
// next-state and result logic for one item of the shuttle sequencer
// depends on lss_pkg
`default_nettype none

module lss_step #(
    parameter int TIMER_BITS = lss_pkg::TIMER_BITS_DEFAULT
) (
    input  wire lss_pkg::lss_cfg_t     cfg,
    input  wire lss_pkg::lss_item_t    item,
    input  wire lss_pkg::lss_state_t   state_cur,
    input  wire [TIMER_BITS-1:0]       turbo_left_cur,
    input  wire [TIMER_BITS-1:0]       brake_left_cur,
    output lss_pkg::lss_state_t        state_next,
    output logic [TIMER_BITS-1:0]      turbo_left_next,
    output logic [TIMER_BITS-1:0]      brake_left_next,
    output lss_pkg::lss_result_t       result
);

    localparam logic [TIMER_BITS-1:0] TIMER_ONE = TIMER_BITS'(1);

    lss_pkg::motion_t   kind;
    logic               treq;
    logic [8:0]         ratio_num;
    logic [8:0]         ratio_inv;
    logic [24:0]        product;
    logic [15:0]        scaled;
    logic [15:0]        len16;
    logic [TIMER_BITS+15:0] len_wide;
    logic [TIMER_BITS+15:0] brake_wide;
    logic [TIMER_BITS-1:0]  len;
    logic [TIMER_BITS-1:0]  brake_load;
    logic               hit;
    lss_pkg::loc_t      hit_loc;
    logic               neg_dir;
    logic [14:0]        speed;

    // command decode: ready from unknown behaves as charge with turbo
    always_comb begin
        kind = lss_pkg::MOT_HOMING;
        treq = item.turbo_request;
        case (item.action)
            lss_pkg::ACT_HOME:   kind = lss_pkg::MOT_HOMING;
            lss_pkg::ACT_CHARGE: kind = lss_pkg::MOT_CHARGING;
            lss_pkg::ACT_READY: begin
                if (state_cur.where_now == lss_pkg::LOC_UNKNOWN) begin
                    kind = lss_pkg::MOT_CHARGING;
                    treq = 1'b1;
                end else begin
                    kind = lss_pkg::MOT_READYING;
                end
            end
            default: kind = lss_pkg::MOT_HOMING;
        endcase
    end

    // turbo length: one shared multiply by the ratio or its complement
    assign ratio_inv = 9'd256 - {1'b0, cfg.ready_ratio};
    assign ratio_num = (kind == lss_pkg::MOT_CHARGING) ? {1'b0, cfg.ready_ratio} : ratio_inv;
    assign product   = {9'd0, cfg.turbo_ticks} * {16'd0, ratio_num};
    assign scaled    = product[23:8];

    always_comb begin
        len16 = 16'd0;
        if (treq && !state_cur.turbo_blocked) begin
            case (kind)
                lss_pkg::MOT_HOMING: begin
                    if (state_cur.where_now == lss_pkg::LOC_READY) len16 = scaled;
                    else if (state_cur.where_now == lss_pkg::LOC_CHARGE) len16 = cfg.turbo_ticks;
                end
                lss_pkg::MOT_CHARGING: begin
                    if (state_cur.where_now == lss_pkg::LOC_HOME) len16 = cfg.turbo_ticks;
                    else if (state_cur.where_now == lss_pkg::LOC_READY) len16 = scaled;
                end
                lss_pkg::MOT_READYING: begin
                    if (state_cur.where_now == lss_pkg::LOC_HOME) len16 = scaled;
                end
                default: len16 = 16'd0;
            endcase
        end
    end

    // fit 16-bit loads to the timer width
    assign len_wide   = {{TIMER_BITS{1'b0}}, len16};
    assign len        = len_wide[TIMER_BITS-1:0];
    assign brake_wide = {{TIMER_BITS{1'b0}}, cfg.brake_interval};
    assign brake_load = brake_wide[TIMER_BITS-1:0];

    // target switch and direction of the running move
    always_comb begin
        hit     = 1'b0;
        hit_loc = lss_pkg::LOC_HOME;
        neg_dir = 1'b1;
        case (state_cur.motion)
            lss_pkg::MOT_HOMING: begin
                hit     = item.home_switch;
                hit_loc = lss_pkg::LOC_HOME;
                neg_dir = 1'b1;
            end
            lss_pkg::MOT_CHARGING: begin
                hit     = item.charge_switch;
                hit_loc = lss_pkg::LOC_CHARGE;
                neg_dir = 1'b0;
            end
            lss_pkg::MOT_READYING: begin
                hit     = item.ready_switch;
                hit_loc = lss_pkg::LOC_READY;
                neg_dir = (state_cur.where_now != lss_pkg::LOC_HOME);
            end
            default: begin
                hit     = 1'b0;
                hit_loc = lss_pkg::LOC_HOME;
                neg_dir = 1'b1;
            end
        endcase
    end

    // state update and result for one item
    always_comb begin
        state_next      = state_cur;
        turbo_left_next = turbo_left_cur;
        brake_left_next = brake_left_cur;
        result          = '0;
        speed           = cfg.normal_speed;

        if (item.action != lss_pkg::ACT_TICK) begin
            // move command, refused while the lock is held
            if (!state_cur.move_lock) begin
                result.accepted        = 1'b1;
                state_next.move_lock   = 1'b1;
                state_next.motion      = kind;
                state_next.update_left = cfg.update_period;
                turbo_left_next        = len;
                state_next.turbo_on    = (len != '0);
            end
        end else begin
            // turbo countdown comes before the motor update
            if (turbo_left_cur != '0) begin
                turbo_left_next = turbo_left_cur - TIMER_ONE;
                if (turbo_left_next == '0) state_next.turbo_on = 1'b0;
            end
            speed = state_next.turbo_on ? cfg.turbo_speed : cfg.normal_speed;

            case (state_cur.motion)
                lss_pkg::MOT_HOMING, lss_pkg::MOT_CHARGING, lss_pkg::MOT_READYING: begin
                    if (state_cur.update_left > 10'd1) begin
                        state_next.update_left = state_cur.update_left - 10'd1;
                    end else begin
                        state_next.update_left = cfg.update_period;
                        result.velocity_write  = 1'b1;
                        if (hit) begin
                            result.brake_pulse       = 1'b1;
                            result.arrived           = 1'b1;
                            state_next.motion        = lss_pkg::MOT_BRAKING;
                            state_next.turbo_blocked = 1'b0;
                            state_next.move_lock     = 1'b0;
                            state_next.where_now     = hit_loc;
                            brake_left_next          = brake_load;
                        end else if (neg_dir) begin
                            result.velocity = -$signed({1'b0, speed});
                        end else begin
                            result.velocity = $signed({1'b0, speed});
                        end
                    end
                end
                lss_pkg::MOT_BRAKING: begin
                    // repeat the brake pulse every interval while stopped
                    if (brake_left_cur > TIMER_ONE) begin
                        brake_left_next = brake_left_cur - TIMER_ONE;
                    end else begin
                        result.brake_pulse = 1'b1;
                        brake_left_next    = brake_load;
                    end
                end
                default: ;
            endcase
        end

        result.location = state_next.where_now;
        result.busy_res = state_next.move_lock;
    end

endmodule

`default_nettype wire

FILE: rtl/core/limit_switch_shuttle_sequencer.sv
// top level of the limit switch shuttle sequencer: channels, registers, config
// depends on lss_pkg, lss_step and assert_macros.svh
//
// Usage: items enter on the s_ channel (valid/ready); each one gives exactly one
// result on the m_ channel. An item is a tick (action 0) or a move command
// (home, charge, ready) with the current limit switch levels. Ticks time the
// turbo phase, the motor update period and the brake repeat interval.
// An accepted item is registered in the input register, then its state update
// is registered in the result register. Throughput: one item per cycle while
// the receiver takes results, set by the state update loop, which holds one
// 16x9 multiply for the scaled turbo length.
// A stalled receiver holds the result register; one more item may wait in the
// input register, after which s_ready drops until the result is taken.
// Reset (aresetn low, synchronous) empties both registers, restores the config
// defaults and sets location unknown, no lock, turbo blocked. Configuration is
// written via cfg_we/cfg_addr/cfg_wdata by the user while idle; not enforced.
`default_nettype none

`include "assert_macros.svh"

module limit_switch_shuttle_sequencer #(
    parameter int TIMER_BITS = lss_pkg::TIMER_BITS_DEFAULT
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // configuration write port
    input  wire                                cfg_we,
    input  wire [lss_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  wire [lss_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    // input item channel
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire [1:0]                          s_action,
    input  wire                                s_turbo_request,
    input  wire                                s_home_switch,
    input  wire                                s_charge_switch,
    input  wire                                s_ready_switch,
    // result channel
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic signed [15:0]                 m_velocity,
    output logic                               m_velocity_write,
    output logic                               m_brake_pulse,
    output logic [1:0]                         m_location,
    output logic                               m_busy_res,
    output logic                               m_accepted,
    output logic                               m_arrived
);

    lss_pkg::lss_cfg_t     cfg_reg;
    lss_pkg::lss_item_t    item_reg;
    logic                  item_valid_reg;
    lss_pkg::lss_state_t   state_reg;
    lss_pkg::lss_state_t   state_next;
    logic [TIMER_BITS-1:0] turbo_left_reg;
    logic [TIMER_BITS-1:0] turbo_left_next;
    logic [TIMER_BITS-1:0] brake_left_reg;
    logic [TIMER_BITS-1:0] brake_left_next;
    lss_pkg::lss_result_t  result_next;
    lss_pkg::lss_result_t  result_reg;
    logic                  out_valid_reg;
    logic                  advance;

    // an item moves on when the result register is free or being emptied
    assign advance = item_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !item_valid_reg || advance;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.normal_speed   <= lss_pkg::RST_NORMAL_SPEED;
            cfg_reg.turbo_speed    <= lss_pkg::RST_TURBO_SPEED;
            cfg_reg.turbo_ticks    <= lss_pkg::RST_TURBO_TICKS;
            cfg_reg.ready_ratio    <= lss_pkg::RST_READY_RATIO;
            cfg_reg.update_period  <= lss_pkg::RST_UPDATE_PERIOD;
            cfg_reg.brake_interval <= lss_pkg::RST_BRAKE_INTERVAL;
        end else if (cfg_we) begin
            case (cfg_addr)
                lss_pkg::CFG_NORMAL_SPEED:   cfg_reg.normal_speed   <= cfg_wdata[14:0];
                lss_pkg::CFG_TURBO_SPEED:    cfg_reg.turbo_speed    <= cfg_wdata[14:0];
                lss_pkg::CFG_TURBO_TICKS:    cfg_reg.turbo_ticks    <= cfg_wdata[15:0];
                lss_pkg::CFG_READY_RATIO:    cfg_reg.ready_ratio    <= cfg_wdata[7:0];
                lss_pkg::CFG_UPDATE_PERIOD:  cfg_reg.update_period  <= cfg_wdata[9:0];
                lss_pkg::CFG_BRAKE_INTERVAL: cfg_reg.brake_interval <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_ready) begin
            item_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.action        <= lss_pkg::action_t'(s_action);
            item_reg.turbo_request <= s_turbo_request;
            item_reg.home_switch   <= s_home_switch;
            item_reg.charge_switch <= s_charge_switch;
            item_reg.ready_switch  <= s_ready_switch;
        end
    end

    lss_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .cfg             (cfg_reg),
        .item            (item_reg),
        .state_cur       (state_reg),
        .turbo_left_cur  (turbo_left_reg),
        .brake_left_cur  (brake_left_reg),
        .state_next      (state_next),
        .turbo_left_next (turbo_left_next),
        .brake_left_next (brake_left_next),
        .result          (result_next)
    );

    // sequencer state, updated once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= lss_pkg::STATE_RESET;
            turbo_left_reg <= '0;
            brake_left_reg <= '0;
        end else if (advance) begin
            state_reg      <= state_next;
            turbo_left_reg <= turbo_left_next;
            brake_left_reg <= brake_left_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_velocity       = result_reg.velocity;
    assign m_velocity_write = result_reg.velocity_write;
    assign m_brake_pulse    = result_reg.brake_pulse;
    assign m_location       = result_reg.location;
    assign m_busy_res       = result_reg.busy_res;
    assign m_accepted       = result_reg.accepted;
    assign m_arrived        = result_reg.arrived;

    // checks
    `ASSERT_IMPL(a_arrive_stops, aclk, aresetn, m_valid && m_arrived,
        !m_busy_res && m_brake_pulse && m_velocity_write && (m_velocity == 16'sd0))
    `ASSERT_IMPL(a_accept_locks, aclk, aresetn, m_valid && m_accepted, m_busy_res)
    `ASSERT_IMPL(a_vel_written, aclk, aresetn, m_valid && (m_velocity != 16'sd0),
        m_velocity_write)
    `ASSERT_NEXT(a_state_holds, aclk, aresetn, !advance,
        $stable(state_reg) && $stable(turbo_left_reg) && $stable(brake_left_reg))

endmodule

`default_nettype wire
